// ===== hdl/rational_arithmetic_unit_top_macros.svh =====
// Assertion macros shared by the checker of the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RAU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rau_pkg.sv =====
package rau_pkg;

   localparam logic [2:0] CMD_ADD  = 3'd0;
   localparam logic [2:0] CMD_SUB  = 3'd1;
   localparam logic [2:0] CMD_MUL  = 3'd2;
   localparam logic [2:0] CMD_DIV  = 3'd3;
   localparam logic [2:0] CMD_CMP  = 3'd4;
   localparam logic [2:0] CMD_NORM = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_OVF  = 2'd2;

   localparam logic [1:0] ORD_LT = 2'd0;
   localparam logic [1:0] ORD_EQ = 2'd1;
   localparam logic [1:0] ORD_GT = 2'd2;

   typedef struct packed {
      logic        direct;
      logic        neg;
      logic [63:0] nm;
      logic [63:0] dm;
      logic [1:0]  order;
      logic [1:0]  status;
   } rau_entry_type;

endpackage

// ===== hdl/rau_if.sv =====
interface rau_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  cmd;
   logic [31:0] a_num;
   logic [31:0] a_den;
   logic [31:0] b_num;
   logic [31:0] b_den;

   modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] res_num;
   logic [30:0] res_den;
   logic [1:0]  order;
   logic [1:0]  status;

   modport source (output valid, res_num, res_den, order, status, input ready);
   modport sink (input valid, res_num, res_den, order, status, output ready);
endinterface

// ===== hdl/rational_arithmetic_unit_top.sv =====
// The front captures a request, forms three products in F_MUL0, F_MUL1 and F_MUL2 and
// pushes an entry to the queue; the back end runs the binary GCD, the divide and the output.
// The back end takes a new entry only when idle, so its rate is set by the binary GCD loop and
// the bit-serial divider; the front handles the next request meanwhile and overlaps it.
// Compare and error transactions bypass the GCD and the divider and go straight to the output.
// Reset is synchronous and active high; it clears control state and the queue only.
module rational_arithmetic_unit_top
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   rau_req_if.sink   req,
   rau_rsp_if.source rsp
);

   logic          push_valid, push_ready, pop_valid, pop_ready;
   rau_entry_type push_entry, pop_entry;

   rau_front #(.WIDTH(WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   rau_back #(.WIDTH(WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp)
   );

endmodule

// ===== hdl/rau_front.sv =====
module rau_front
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   rau_req_if.sink       req,
   output logic          push_valid,
   input  logic          push_ready,
   output rau_entry_type push_entry
);

   localparam int SH = 32 - WIDTH;

   localparam logic [2:0] F_IDLE = 3'd0;
   localparam logic [2:0] F_MUL0 = 3'd1;
   localparam logic [2:0] F_MUL1 = 3'd2;
   localparam logic [2:0] F_MUL2 = 3'd3;
   localparam logic [2:0] F_PUSH = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  cmd_ff;
   logic        err_ff;
   logic [3:0]  sgn_ff;
   logic [31:0] man_ff, mad_ff, mbn_ff, mbd_ff;
   logic [63:0] p0_ff, p1_ff, p2_ff;

   logic signed [31:0] sx_an, sx_ad, sx_bn, sx_bd;
   logic [31:0] m_an, m_ad, m_bn, m_bd;
   logic        err;
   logic [31:0] mx, my;
   logic [63:0] prod;
   logic        s1, s2, ds;
   logic [63:0] sum, d12, d21;
   logic signed [64:0] lhs, rhs;

   assign sx_an = $signed(req.a_num << SH) >>> SH;
   assign sx_ad = $signed(req.a_den << SH) >>> SH;
   assign sx_bn = $signed(req.b_num << SH) >>> SH;
   assign sx_bd = $signed(req.b_den << SH) >>> SH;
   assign m_an = sx_an[31] ? (~sx_an + 32'd1) : sx_an;
   assign m_ad = sx_ad[31] ? (~sx_ad + 32'd1) : sx_ad;
   assign m_bn = sx_bn[31] ? (~sx_bn + 32'd1) : sx_bn;
   assign m_bd = sx_bd[31] ? (~sx_bd + 32'd1) : sx_bd;

   assign err = (req.cmd > CMD_NORM) || (m_ad == 32'd0) ||
                ((req.cmd != CMD_NORM) && (m_bd == 32'd0)) ||
                ((req.cmd == CMD_DIV) && (m_bn == 32'd0));

   assign req.ready = (state_ff == F_IDLE);

   always_comb begin
      mx = mad_ff;
      my = mbd_ff;
      case (state_ff)
         F_MUL0: begin
            mx = man_ff;
            my = (cmd_ff == CMD_MUL) ? mbn_ff : mbd_ff;
         end
         F_MUL1: begin
            mx = mad_ff;
            my = mbn_ff;
         end
         default: begin
            mx = mad_ff;
            my = mbd_ff;
         end
      endcase
   end

   assign prod = {32'd0, mx} * {32'd0, my};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (req.valid) state_in = F_MUL0;
         F_MUL0: state_in = F_MUL1;
         F_MUL1: state_in = F_MUL2;
         F_MUL2: state_in = F_PUSH;
         F_PUSH: if (push_ready) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && req.valid) begin
         cmd_ff <= req.cmd;
         err_ff <= err;
         sgn_ff <= {sx_an[31], sx_ad[31], sx_bn[31], sx_bd[31]};
         man_ff <= m_an;
         mad_ff <= m_ad;
         mbn_ff <= m_bn;
         mbd_ff <= m_bd;
      end
      if (state_ff == F_MUL0) p0_ff <= prod;
      if (state_ff == F_MUL1) p1_ff <= prod;
      if (state_ff == F_MUL2) p2_ff <= prod;
   end

   // Sign bits are held as {an, ad, bn, bd}.
   assign s1  = sgn_ff[3] ^ sgn_ff[0];
   assign s2  = sgn_ff[2] ^ sgn_ff[1] ^ (cmd_ff == CMD_SUB);
   assign ds  = sgn_ff[2] ^ sgn_ff[0];
   assign sum = p0_ff + p1_ff;
   assign d12 = p0_ff - p1_ff;
   assign d21 = p1_ff - p0_ff;
   assign lhs = (sgn_ff[3] ^ sgn_ff[2]) ? -$signed({1'b0, p0_ff}) : $signed({1'b0, p0_ff});
   assign rhs = (sgn_ff[1] ^ sgn_ff[0]) ? -$signed({1'b0, p1_ff}) : $signed({1'b0, p1_ff});

   always_comb begin
      logic ns;
      ns = 1'b0;
      push_entry = '0;
      push_entry.status = ST_OK;
      push_entry.order = ORD_LT;
      push_entry.dm = p2_ff;
      case (cmd_ff)
         CMD_ADD, CMD_SUB: begin
            if (s1 == s2) begin
               push_entry.nm = sum;
               ns = s1;
            end else if (p0_ff >= p1_ff) begin
               push_entry.nm = d12;
               ns = s1;
            end else begin
               push_entry.nm = d21;
               ns = s2;
            end
            push_entry.neg = (ns != ds) && (push_entry.nm != 64'd0);
         end
         CMD_MUL: begin
            push_entry.nm = p0_ff;
            push_entry.neg = (sgn_ff[3] ^ sgn_ff[1] ^ ds) && (p0_ff != 64'd0);
         end
         CMD_DIV: begin
            push_entry.nm = p0_ff;
            push_entry.dm = p1_ff;
            push_entry.neg = (sgn_ff[3] ^ sgn_ff[0] ^ sgn_ff[2] ^ sgn_ff[1]) &&
                             (p0_ff != 64'd0);
         end
         CMD_CMP: begin
            push_entry.direct = 1'b1;
            push_entry.order = (lhs < rhs) ? ORD_LT : ((lhs == rhs) ? ORD_EQ : ORD_GT);
         end
         default: begin
            push_entry.nm = {32'd0, man_ff};
            push_entry.dm = {32'd0, mad_ff};
            push_entry.neg = (sgn_ff[3] ^ sgn_ff[2]) && (man_ff != 32'd0);
         end
      endcase
      if (err_ff) begin
         push_entry = '0;
         push_entry.direct = 1'b1;
         push_entry.status = ST_ZERO;
      end
   end

   assign push_valid = (state_ff == F_PUSH);

endmodule

// ===== hdl/rau_queue.sv =====
module rau_queue
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   output logic          push_ready,
   input  rau_entry_type push_entry,
   output logic          pop_valid,
   input  logic          pop_ready,
   output rau_entry_type pop_entry
);

   rau_entry_type slot_ff [2];
   logic          wr_ptr_ff, rd_ptr_ff;
   logic [1:0]    count_ff;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop) rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== hdl/rau_back.sv =====
module rau_back
   import rau_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   output logic          pop_ready,
   input  rau_entry_type pop_entry,
   rau_rsp_if.source     rsp
);

   localparam logic [63:0] LIM = (64'd1 << (WIDTH - 1)) - 64'd1;

   localparam logic [1:0] B_IDLE = 2'd0;
   localparam logic [1:0] B_GCD  = 2'd1;
   localparam logic [1:0] B_DIV  = 2'd2;
   localparam logic [1:0] B_OUT  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        direct_ff, neg_ff;
   logic [1:0]  order_ff, status_ff;
   logic [63:0] u_ff, v_ff, g_ff, qn_ff, qd_ff, rn_ff, rd_ff;
   logic [5:0]  k_ff, cnt_ff;
   logic        valid_ff;
   logic [31:0] num_ff;
   logic [30:0] den_ff;
   logic [1:0]  ord_out_ff, st_out_ff;

   logic        gcd_done, out_free, ovf;
   logic [63:0] g_val, u_sub, v_sub;
   logic [64:0] tn, td;
   logic        bn, bd;

   assign out_free  = !valid_ff || rsp.ready;
   assign pop_ready = (state_ff == B_IDLE);
   assign gcd_done  = (u_ff == 64'd0) || (v_ff == 64'd0);
   assign g_val     = (u_ff == 64'd0) ? (v_ff << k_ff) : (u_ff << k_ff);
   assign u_sub     = u_ff - v_ff;
   assign v_sub     = v_ff - u_ff;
   assign tn        = {rn_ff, qn_ff[63]};
   assign td        = {rd_ff, qd_ff[63]};
   assign bn        = (tn >= {1'b0, g_ff});
   assign bd        = (td >= {1'b0, g_ff});
   assign ovf       = (qd_ff > LIM) || (qn_ff > (LIM + {63'd0, neg_ff}));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (pop_valid) state_in = pop_entry.direct ? B_OUT : B_GCD;
         B_GCD: if (gcd_done) state_in = B_DIV;
         B_DIV: if (cnt_ff == 6'd63) state_in = B_OUT;
         B_OUT: if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == B_OUT && out_free) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               direct_ff <= pop_entry.direct;
               neg_ff    <= pop_entry.neg;
               order_ff  <= pop_entry.order;
               status_ff <= pop_entry.status;
               u_ff      <= pop_entry.nm;
               v_ff      <= pop_entry.dm;
               qn_ff     <= pop_entry.nm;
               qd_ff     <= pop_entry.dm;
               k_ff      <= 6'd0;
            end
         end
         B_GCD: begin
            if (gcd_done) begin
               g_ff   <= g_val;
               rn_ff  <= 64'd0;
               rd_ff  <= 64'd0;
               cnt_ff <= 6'd0;
            end else if (!u_ff[0] && !v_ff[0]) begin
               u_ff <= u_ff >> 1;
               v_ff <= v_ff >> 1;
               k_ff <= k_ff + 6'd1;
            end else if (!u_ff[0]) begin
               u_ff <= u_ff >> 1;
            end else if (!v_ff[0]) begin
               v_ff <= v_ff >> 1;
            end else if (u_ff >= v_ff) begin
               u_ff <= u_sub >> 1;
            end else begin
               v_ff <= v_sub >> 1;
            end
         end
         B_DIV: begin
            rn_ff  <= bn ? 64'(tn - {1'b0, g_ff}) : tn[63:0];
            rd_ff  <= bd ? 64'(td - {1'b0, g_ff}) : td[63:0];
            qn_ff  <= {qn_ff[62:0], bn};
            qd_ff  <= {qd_ff[62:0], bd};
            cnt_ff <= cnt_ff + 6'd1;
         end
         default: begin
            if (out_free) begin
               if (direct_ff) begin
                  num_ff     <= 32'd0;
                  den_ff     <= 31'd0;
                  ord_out_ff <= order_ff;
                  st_out_ff  <= status_ff;
               end else if (ovf) begin
                  num_ff     <= 32'd0;
                  den_ff     <= 31'd0;
                  ord_out_ff <= ORD_LT;
                  st_out_ff  <= ST_OVF;
               end else begin
                  num_ff     <= neg_ff ? 32'(-qn_ff) : qn_ff[31:0];
                  den_ff     <= qd_ff[30:0];
                  ord_out_ff <= ORD_LT;
                  st_out_ff  <= ST_OK;
               end
            end
         end
      endcase
   end

   assign rsp.valid   = valid_ff;
   assign rsp.res_num = num_ff;
   assign rsp.res_den = den_ff;
   assign rsp.order   = ord_out_ff;
   assign rsp.status  = st_out_ff;

endmodule

// ===== hdl/rau_checker.sv =====
`include "rational_arithmetic_unit_top_macros.svh"

module rau_checker
   import rau_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_res_num,
   input logic [30:0] rsp_res_den,
   input logic [1:0]  rsp_order,
   input logic [1:0]  rsp_status
);

   `RAU_ASSERT_NOW(a_stall_hold, rsp_valid && !rsp_ready, ##1 rsp_valid && $stable(rsp_res_num), "stalled result changed")
   `RAU_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_res_num == 32'd0 && rsp_res_den == 31'd0 && rsp_order == ORD_LT, "error result has nonzero fields")
   `RAU_ASSERT_NOW(a_cmp_zero, rsp_valid && rsp_order != ORD_LT, rsp_res_den == 31'd0 && rsp_res_num == 32'd0 && rsp_status == ST_OK, "compare result has fraction fields")
   `RAU_ASSERT_NEXT(a_reset_idle, reset, !rsp_valid, "result valid right after reset")

endmodule

bind rational_arithmetic_unit_top rau_checker u_rau_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_res_num (rsp.res_num),
   .rsp_res_den (rsp.res_den),
   .rsp_order   (rsp.order),
   .rsp_status  (rsp.status)
);
